// File: src/mbet_pkg.sv
// Package: shared types and constants for the multibrot escape-time block.
`timescale 1ns / 1ps
package mbet_pkg;
   localparam int unsigned CFG_IDX_W = 2;
   localparam logic [CFG_IDX_W-1:0] CFG_EXPONENT = 2'd0;
   localparam logic [CFG_IDX_W-1:0] CFG_BAILOUT  = 2'd1;
   localparam logic [CFG_IDX_W-1:0] CFG_MAXITER  = 2'd2;

   // Which product the shared multiplier forms this cycle.
   typedef enum logic [1:0] {
      MUL_AC = 2'd0,
      MUL_BD = 2'd1,
      MUL_AD = 2'd2,
      MUL_BC = 2'd3
   } mul_sel_type;

   // Controller to datapath.
   typedef struct packed {
      logic        load;      // start a point: clear z, latch c
      logic        mul_en;    // form one product, accumulate
      mul_sel_type mul_sel;
      logic        cmul_done; // commit product into p
      logic        start_p;   // p = z
      logic        add_c;     // z = p + c
      logic        norm_re;   // norm step 1
      logic        norm_im;   // norm step 2
   } dp_cmd_type;

   // Datapath to controller.
   typedef struct packed {
      logic escape;
   } dp_sts_type;
endpackage

// File: src/mbet_if.sv
// Interfaces: valid/ready channels for points, results and register writes.
`timescale 1ns / 1ps
interface mbet_req_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] c_real;
   logic signed [31:0] c_imag;
   modport source (output valid, c_real, c_imag, input ready);
   modport sink   (input valid, c_real, c_imag, output ready);
endinterface

interface mbet_rsp_if #(parameter int ITER_WIDTH = 16);
   logic                  valid;
   logic                  ready;
   logic [ITER_WIDTH-1:0] iteration_count;
   logic                  inside_set;
   logic signed [31:0]    final_real;
   logic signed [31:0]    final_imag;
   logic [62:0]           final_norm;
   modport source (output valid, iteration_count, inside_set, final_real, final_imag,
                   final_norm, input ready);
   modport sink   (input valid, iteration_count, inside_set, final_real, final_imag,
                   final_norm, output ready);
endinterface

interface mbet_csr_if;
   logic        valid;
   logic        ready;
   logic [1:0]  index;
   logic [31:0] data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// File: src/mbet_datapath.sv
// Datapath: z, p and c registers, one shared 32x32 multiplier, norm and escape test.
`timescale 1ns / 1ps
module mbet_datapath #(
   parameter int FRAC_BITS = 24
) (
   input  logic                 clock,
   input  mbet_pkg::dp_cmd_type cmd,
   output mbet_pkg::dp_sts_type sts,
   input  logic signed [31:0]   c_real,
   input  logic signed [31:0]   c_imag,
   input  logic [30:0]          bailout_radius,
   output logic signed [31:0]   z_real,
   output logic signed [31:0]   z_imag,
   output logic [62:0]          z_norm
);
   import mbet_pkg::*;

   localparam logic signed [65:0] S_MAX = 66'sd2147483647;
   localparam logic signed [65:0] S_MIN = -66'sd2147483648;

   logic signed [31:0] cr_ff, ci_ff, zr_ff, zi_ff, pr_ff, pi_ff;
   logic signed [31:0] cr_in, ci_in, zr_in, zi_in, pr_in, pi_in;
   logic signed [65:0] re_acc_ff, im_acc_ff, re_acc_in, im_acc_in;
   logic signed [65:0] re_nx, im_nx;
   logic signed [63:0] prod_ff, prod_in;
   logic               prod_v_ff, prod_v_in;
   mul_sel_type        prod_sel_ff, prod_sel_in;
   logic               ovf_ff, ovf_in;
   logic [63:0]        sum_ff, sum_in;
   logic [61:0]        bsq_ff;
   logic               bsq_v_ff;
   logic signed [31:0] ma, mb;
   logic signed [63:0] mprod;
   logic signed [31:0] sr, si;
   logic               ovr, ovi;
   logic signed [32:0] addr, addi;
   logic signed [63:0] shp;

   // operand select for the shared multiplier
   always_comb begin
      unique case (cmd.mul_sel)
         MUL_AC:  begin ma = pr_ff; mb = zr_ff; end
         MUL_BD:  begin ma = pi_ff; mb = zi_ff; end
         MUL_AD:  begin ma = pr_ff; mb = zi_ff; end
         default: begin ma = pi_ff; mb = zr_ff; end
      endcase
      if (cmd.norm_re) begin
         ma = zr_ff; mb = zr_ff;
      end else if (cmd.norm_im) begin
         ma = zi_ff; mb = zi_ff;
      end
   end

   assign mprod = ma * mb;

   // arithmetic shift is floor division by 2^FRAC_BITS
   assign shp = prod_ff >>> FRAC_BITS;

   // last registered product folded into the running sums
   always_comb begin
      re_nx = re_acc_ff; im_nx = im_acc_ff;
      if (prod_v_ff) begin
         unique case (prod_sel_ff)
            MUL_AC:  re_nx = re_acc_ff + 66'(shp);
            MUL_BD:  re_nx = re_acc_ff - 66'(shp);
            default: im_nx = im_acc_ff + 66'(shp);
         endcase
      end
   end

   always_comb begin
      if (re_nx > S_MAX) begin sr = 32'sh7fffffff; ovr = 1'b1; end
      else if (re_nx < S_MIN) begin sr = 32'sh80000000; ovr = 1'b1; end
      else begin sr = re_nx[31:0]; ovr = 1'b0; end
      if (im_nx > S_MAX) begin si = 32'sh7fffffff; ovi = 1'b1; end
      else if (im_nx < S_MIN) begin si = 32'sh80000000; ovi = 1'b1; end
      else begin si = im_nx[31:0]; ovi = 1'b0; end
   end

   assign addr = {pr_ff[31], pr_ff} + {cr_ff[31], cr_ff};
   assign addi = {pi_ff[31], pi_ff} + {ci_ff[31], ci_ff};

   always_comb begin
      cr_in = cr_ff; ci_in = ci_ff; zr_in = zr_ff; zi_in = zi_ff;
      pr_in = pr_ff; pi_in = pi_ff; ovf_in = ovf_ff; sum_in = sum_ff;
      re_acc_in = re_nx; im_acc_in = im_nx;
      prod_in = mprod;
      prod_v_in = cmd.mul_en;
      prod_sel_in = cmd.mul_sel;
      if (cmd.load) begin
         cr_in = c_real; ci_in = c_imag; zr_in = '0; zi_in = '0;
         sum_in = '0;
      end
      if (cmd.start_p) begin
         pr_in = zr_ff; pi_in = zi_ff; ovf_in = 1'b0;
         re_acc_in = '0; im_acc_in = '0;
      end
      if (cmd.cmul_done) begin
         pr_in = sr; pi_in = si; ovf_in = ovf_ff | ovr | ovi;
         re_acc_in = '0; im_acc_in = '0;
      end
      if (cmd.add_c) begin
         if (addr > 33'sd2147483647) begin zr_in = 32'sh7fffffff; ovf_in = 1'b1; end
         else if (addr < -33'sd2147483648) begin zr_in = 32'sh80000000; ovf_in = 1'b1; end
         else zr_in = addr[31:0];
         if (addi > 33'sd2147483647) begin zi_in = 32'sh7fffffff; ovf_in = 1'b1; end
         else if (addi < -33'sd2147483648) begin zi_in = 32'sh80000000; ovf_in = 1'b1; end
         else zi_in = addi[31:0];
      end
      if (cmd.norm_re) sum_in = $unsigned(mprod);
      if (cmd.norm_im) sum_in = sum_ff + $unsigned(mprod);
   end

   always_ff @(posedge clock) begin
      cr_ff <= cr_in; ci_ff <= ci_in; zr_ff <= zr_in; zi_ff <= zi_in;
      pr_ff <= pr_in; pi_ff <= pi_in; ovf_ff <= ovf_in; sum_ff <= sum_in;
      re_acc_ff <= re_acc_in; im_acc_ff <= im_acc_in;
      prod_ff <= prod_in; prod_v_ff <= prod_v_in; prod_sel_ff <= prod_sel_in;
      bsq_v_ff <= cmd.load;
      if (bsq_v_ff) bsq_ff <= {31'd0, bailout_radius} * {31'd0, bailout_radius};
   end

   assign sts.escape = ovf_ff | (sum_ff > {2'b00, bsq_ff});
   assign z_real = zr_ff;
   assign z_imag = zi_ff;
   assign z_norm = sum_ff[63] ? {63{1'b1}} : sum_ff[62:0];
endmodule

// File: src/mbet_ctrl.sv
// Controller: sequences complex multiplies, additions and escape tests per point.
`timescale 1ns / 1ps
module mbet_ctrl #(
   parameter int MAX_EXPONENT = 16,
   parameter int ITER_WIDTH   = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  logic [4:0]            exponent,
   input  logic [15:0]           max_iterations,
   output mbet_pkg::dp_cmd_type  cmd,
   input  mbet_pkg::dp_sts_type  sts,
   output logic [ITER_WIDTH-1:0] count,
   output logic                  in_set,
   output logic                  capture
);
   import mbet_pkg::*;

   localparam int EW = $clog2(MAX_EXPONENT + 1);

   typedef enum logic [7:0] {
      S_IDLE  = 8'b00000001,
      S_START = 8'b00000010,
      S_MUL   = 8'b00000100,
      S_DRAIN = 8'b00001000,
      S_ADD   = 8'b00010000,
      S_NORM  = 8'b00100000,
      S_TEST  = 8'b01000000,
      S_OUT   = 8'b10000000
   } state_type;

   state_type state_ff, state_in;
   logic [EW-1:0]         k_ff, k_in, m_ff, m_in;
   logic [1:0]            ph_ff, ph_in;
   logic [ITER_WIDTH-1:0] it_ff, it_in, lim_ff, lim_in;
   logic                  inside_ff, inside_in, vld_ff, vld_in;
   logic [EW-1:0]         m_clamp;

   always_comb begin
      if (exponent < 5'd2) m_clamp = EW'(2);
      else if (32'(exponent) > MAX_EXPONENT) m_clamp = EW'(MAX_EXPONENT);
      else m_clamp = EW'(exponent);
   end

   // a finished result waits in the output register, so a new point may start
   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      state_in = state_ff; k_in = k_ff; m_in = m_ff; ph_in = ph_ff;
      it_in = it_ff; lim_in = lim_ff; inside_in = inside_ff; vld_in = vld_ff;
      cmd = '0;
      capture = 1'b0;
      if (vld_ff && rsp_ready) vld_in = 1'b0;
      unique case (state_ff)
         S_IDLE: if (req_valid && req_ready) begin
            cmd.load = 1'b1;
            m_in = m_clamp;
            lim_in = ITER_WIDTH'(max_iterations);
            it_in = '0;
            inside_in = 1'b1;
            state_in = (max_iterations == 16'd0) ? S_OUT : S_START;
         end
         S_START: begin
            cmd.start_p = 1'b1; k_in = EW'(1); ph_in = 2'd0; state_in = S_MUL;
         end
         S_MUL: begin
            cmd.mul_en = 1'b1;
            cmd.mul_sel = mul_sel_type'(ph_ff);
            ph_in = ph_ff + 2'd1;
            if (ph_ff == 2'd3) state_in = S_DRAIN;
         end
         S_DRAIN: begin
            cmd.cmul_done = 1'b1;
            k_in = k_ff + EW'(1);
            ph_in = 2'd0;
            state_in = (k_ff + EW'(1) == m_ff) ? S_ADD : S_MUL;
         end
         S_ADD:  begin cmd.add_c = 1'b1; state_in = S_NORM; ph_in = 2'd0; end
         S_NORM: begin
            if (ph_ff == 2'd0) begin cmd.norm_re = 1'b1; ph_in = 2'd1; end
            else begin cmd.norm_im = 1'b1; state_in = S_TEST; end
         end
         S_TEST: begin
            if (sts.escape) begin
               inside_in = 1'b0; state_in = S_OUT;
            end else if (it_ff + ITER_WIDTH'(1) == lim_ff) begin
               it_in = lim_ff; state_in = S_OUT;
            end else begin
               it_in = it_ff + ITER_WIDTH'(1); state_in = S_START;
            end
         end
         S_OUT: if (!vld_ff) begin
            capture = 1'b1; vld_in = 1'b1; state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE; vld_ff <= 1'b0;
      end else begin
         state_ff <= state_in; vld_ff <= vld_in;
      end
      k_ff <= k_in; m_ff <= m_in; ph_ff <= ph_in; it_ff <= it_in;
      lim_ff <= lim_in; inside_ff <= inside_in;
   end

   assign rsp_valid = vld_ff;
   assign count = it_ff;
   assign in_set = inside_ff;
endmodule

// File: src/multibrot_escape_time.sv
// Top level: multibrot escape-time engine with register port.
`timescale 1ns / 1ps
// Takes one point c per req beat and returns one rsp beat with the escape
// iteration, in-set flag, final z and its squared norm. One point is iterated
// at a time; a finished result waits in the output register, so the next
// point can be taken while that result is still unread. Each iteration runs
// on one shared 32x32 multiplier: a start step, m-1 complex multiplies of four
// products plus a drain, the add of c, two norm steps and the escape test. A
// point runs N iterations (escape index + 1 if it escapes, max_iterations if it
// stays in, 0 for a zero limit). Write registers only when the block is idle.
module multibrot_escape_time #(
   parameter int FRAC_BITS    = 24,
   parameter int MAX_EXPONENT = 16,
   parameter int ITER_WIDTH   = 16
) (
   input logic clock,
   input logic reset,
   mbet_req_if.sink             req,
   mbet_rsp_if.source           rsp,
   mbet_csr_if.sink             csr
);
   import mbet_pkg::*;

   logic [4:0]  exponent_ff;
   logic [30:0] bailout_ff;
   logic [15:0] maxit_ff;
   dp_cmd_type  cmd;
   dp_sts_type  sts;
   logic [ITER_WIDTH-1:0] count;
   logic        in_set, capture;
   logic signed [31:0] zr, zi;
   logic [62:0] zn;

   assign csr.ready = 1'b1;

   // register file
   always_ff @(posedge clock) begin
      if (reset) begin
         exponent_ff <= 5'd2;
         bailout_ff  <= 31'd33554432;
         maxit_ff    <= 16'd256;
      end else if (csr.valid) begin
         unique case (csr.index)
            CFG_EXPONENT: exponent_ff <= csr.data[4:0];
            CFG_BAILOUT:  bailout_ff  <= csr.data[30:0];
            CFG_MAXITER:  maxit_ff    <= csr.data[15:0];
            default: ;
         endcase
      end
   end

   mbet_ctrl #(.MAX_EXPONENT(MAX_EXPONENT), .ITER_WIDTH(ITER_WIDTH)) u_ctrl (
      .clock, .reset,
      .req_valid(req.valid), .req_ready(req.ready),
      .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
      .exponent(exponent_ff), .max_iterations(maxit_ff),
      .cmd, .sts, .count, .in_set, .capture
   );

   mbet_datapath #(.FRAC_BITS(FRAC_BITS)) u_dp (
      .clock, .cmd, .sts,
      .c_real(req.c_real), .c_imag(req.c_imag),
      .bailout_radius(bailout_ff),
      .z_real(zr), .z_imag(zi), .z_norm(zn)
   );

   // result register, held until the rsp beat goes
   always_ff @(posedge clock) begin
      if (capture) begin
         rsp.iteration_count <= count;
         rsp.inside_set      <= in_set;
         rsp.final_real      <= zr;
         rsp.final_imag      <= zi;
         rsp.final_norm      <= zn;
      end
   end

`ifndef SYNTHESIS
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      capture |-> !rsp.valid) else $error("result overwritten while pending");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && !rsp.ready |=> rsp.valid) else $error("result dropped");
   a_inside_count: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp.valid) && !rsp.inside_set |-> rsp.iteration_count < ITER_WIDTH'(maxit_ff))
      else $error("escape index beyond limit");
`endif
endmodule

// File: dv/multibrot_escape_time_scoreboard.sv
// Escape-time predictor and result checker for the multibrot block.
`timescale 1ns / 1ps
class escape_scoreboard;
   typedef struct packed {
      logic [15:0]        count;
      logic               in_set;
      logic signed [31:0] zr;
      logic signed [31:0] zi;
      logic [62:0]        norm;
   } escape_result_type;

   logic [4:0]  exponent;
   logic [30:0] bailout;
   logic [15:0] max_iter;
   escape_result_type pending[$];
   int unsigned errors;

   function new();
      exponent = 5'd2;
      bailout  = 31'd33554432;
      max_iter = 16'd256;
      errors   = 0;
   endfunction

   function void write_reg(logic [1:0] idx, logic [31:0] data);
      case (idx)
         mbet_pkg::CFG_EXPONENT: exponent = data[4:0];
         mbet_pkg::CFG_BAILOUT:  bailout  = data[30:0];
         mbet_pkg::CFG_MAXITER:  max_iter = data[15:0];
         default: ;
      endcase
   endfunction

   // Floor division by 2^24 is an arithmetic right shift.
   static function longint shr_floor(longint v);
      return v >>> 24;
   endfunction

   static function longint clip32(longint v, ref bit ovf);
      if (v > 64'sd2147483647) begin
         ovf = 1;
         return 64'sd2147483647;
      end
      if (v < -64'sd2147483648) begin
         ovf = 1;
         return -64'sd2147483648;
      end
      return v;
   endfunction

   function void note_point(logic signed [31:0] cr, logic signed [31:0] ci);
      escape_result_type r;
      longint zr, zi, pr, pi, nr, ni;
      logic [63:0] bsq, sum;
      int m;
      bit ovf;
      zr = 0;
      zi = 0;
      m = exponent < 2 ? 2 : (exponent > 16 ? 16 : exponent);
      bsq = 64'(bailout) * 64'(bailout);
      r.count = max_iter;
      r.in_set = 1;
      r.norm = 0;
      for (int it = 0; it < max_iter; it++) begin
         ovf = 0;
         pr = zr;
         pi = zi;
         for (int k = 1; k < m; k++) begin
            nr = shr_floor(pr * zr) - shr_floor(pi * zi);
            ni = shr_floor(pr * zi) + shr_floor(pi * zr);
            pr = clip32(nr, ovf);
            pi = clip32(ni, ovf);
         end
         zr = clip32(pr + cr, ovf);
         zi = clip32(pi + ci, ovf);
         sum = 64'(zr * zr) + 64'(zi * zi);
         r.norm = sum[63] ? {63{1'b1}} : sum[62:0];
         if (ovf || sum > bsq) begin
            r.in_set = 0;
            r.count = it[15:0];
            break;
         end
      end
      r.zr = zr[31:0];
      r.zi = zi[31:0];
      pending.push_back(r);
   endfunction

   function void check_result(logic [15:0] count, logic in_set, logic signed [31:0] zr,
                              logic signed [31:0] zi, logic [62:0] norm);
      escape_result_type e;
      if (pending.size() == 0) begin
         $error("result beat with nothing expected");
         errors++;
         return;
      end
      e = pending.pop_front();
      if (count !== e.count) begin
         $error("iteration_count expected %0d actual %0d", e.count, count);
         errors++;
      end
      if (in_set !== e.in_set) begin
         $error("inside_set expected %0d actual %0d", e.in_set, in_set);
         errors++;
      end
      if (zr !== e.zr) begin
         $error("final_real expected %0d actual %0d", e.zr, zr);
         errors++;
      end
      if (zi !== e.zi) begin
         $error("final_imag expected %0d actual %0d", e.zi, zi);
         errors++;
      end
      if (norm !== e.norm) begin
         $error("final_norm expected %0d actual %0d", e.norm, norm);
         errors++;
      end
   endfunction
endclass

// File: dv/multibrot_escape_time_test.sv
// Testbench top: drives points and register writes, checks every result beat.
`timescale 1ns / 1ps
module multibrot_escape_time_test;
   import mbet_pkg::*;

   // cycles without any beat; above what one point at the full limit needs
   localparam int IDLE_LIMIT = 4000000;

   logic clock = 0;
   logic reset = 1;
   always #2 clock = ~clock;

   mbet_req_if req ();
   mbet_rsp_if #(.ITER_WIDTH(16)) rsp ();
   mbet_csr_if csr ();

   multibrot_escape_time uut (
      .clock(clock), .reset(reset), .req(req.sink), .rsp(rsp.source), .csr(csr.sink)
   );

   escape_scoreboard board = new();
   int unsigned send_idle = 0;   // percent of cycles the sender holds back
   int unsigned recv_stall = 0;  // percent of cycles the receiver stalls
   int unsigned quiet_cycles = 0;

   initial begin
      req.valid = 0;
      req.c_real = 0;
      req.c_imag = 0;
      rsp.ready = 0;
      csr.valid = 0;
      csr.index = CFG_EXPONENT;
      csr.data = 0;
   end

   // Receiver: ready toggled on the falling edge, beat checked at the rising edge.
   always @(negedge clock)
      if (!reset) rsp.ready <= ($urandom_range(99) >= recv_stall);

   always @(posedge clock) begin
      if (!reset && rsp.valid && rsp.ready)
         board.check_result(rsp.iteration_count, rsp.inside_set, rsp.final_real,
                            rsp.final_imag, rsp.final_norm);
   end

   // Watchdog: any beat on any channel counts as progress.
   always @(posedge clock) begin
      if ((req.valid && req.ready) || (rsp.valid && rsp.ready) || (csr.valid && csr.ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= IDLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   // valid stays up after the beat; drain() drops it, or the next call while it holds back
   task automatic send_point(logic signed [31:0] cr, logic signed [31:0] ci);
      while ($urandom_range(99) < send_idle) begin
         req.valid <= 0;
         @(negedge clock);
      end
      req.valid <= 1;
      req.c_real <= cr;
      req.c_imag <= ci;
      do @(posedge clock); while (!req.ready);
      board.note_point(cr, ci);
      @(negedge clock);
   endtask

   // valid stays up after the beat; set_regs drops it after the last write
   task automatic write_reg(logic [1:0] idx, logic [31:0] data);
      csr.valid <= 1;
      csr.index <= idx;
      csr.data <= data;
      do @(posedge clock); while (!csr.ready);
      board.write_reg(idx, data);
      @(negedge clock);
   endtask

   // Registers change only once every result is back, plus a short settle.
   task automatic drain();
      req.valid <= 0;
      while (board.pending.size() != 0) @(negedge clock);
      repeat (20) @(negedge clock);
   endtask

   task automatic set_regs(logic [4:0] m, logic [30:0] radius, logic [15:0] limit);
      drain();
      write_reg(CFG_EXPONENT, 32'(m));
      write_reg(CFG_BAILOUT, 32'(radius));
      write_reg(CFG_MAXITER, 32'(limit));
      csr.valid <= 0;
   endtask

   // Mostly points near the set, where iteration runs long; some full-range noise.
   function automatic logic signed [31:0] pick_coord();
      case ($urandom_range(9))
         0, 1:    return $urandom();
         2:       return $urandom_range(1) ? 32'sh7FFFFFFF : 32'sh80000000;
         default: return $signed($urandom_range(32'h04000000)) - 32'sh02000000;
      endcase
   endfunction

   task automatic random_phase(int n);
      for (int i = 0; i < n; i++) send_point(pick_coord(), pick_coord());
   endtask

   initial begin
      logic signed [31:0] corner[5] = '{32'sh80000000, 32'sh7FFFFFFF, 0, -1, 32'sh01000000};
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 0;

      // Directed: reset settings first, corners of both fields.
      foreach (corner[i]) send_point(corner[i], corner[(i + 2) % 5]);
      send_point(32'shFF400000, 0); // -0.75: stays inside the full limit
      set_regs(5'd0, 31'd0, 16'd0);           // zero limit, exponent below range
      send_point(32'sh12345678, -32'sh1);
      set_regs(5'd31, 31'd0, 16'd5);          // exponent above range, zero radius
      send_point(0, 0);
      send_point(1, 0);
      send_point(32'sh00800000, 32'sh00400000);
      set_regs(5'd16, 31'h7FFFFFFF, 16'd3);   // huge radius: escape only near the edge of the number range
      send_point(32'sh7FFFFFFF, 32'sh7FFFFFFF);
      send_point(32'sh00C00000, 32'sh00C00000);
      set_regs(5'd3, 31'd33554432, 16'd1);    // single iteration
      send_point(32'sh02000000, 0);
      send_point(32'sh02000001, 0);

      // Random phases through a spread of settings and idling patterns.
      send_idle = 25; recv_stall = 64;
      set_regs(5'd2, 31'd33554432, 16'd20);  random_phase(200);
      set_regs(5'd5, 31'd16777216, 16'd12);  random_phase(190);
      send_idle = 64; recv_stall = 25;
      set_regs(5'd16, 31'd50331648, 16'd6);  random_phase(190);
      set_regs(5'd3, 31'h7FFFFFFF, 16'd10);  random_phase(190);
      send_idle = 0; recv_stall = 0;
      set_regs(5'($urandom_range(2, 16)), 31'($urandom()), 16'($urandom_range(1, 16)));
      random_phase(190);
      set_regs(5'd2, 31'd33554432, 16'd60);  random_phase(180);
      set_regs(5'd2, 31'd33554432, 16'd65535);
      send_point(0, 0);                        // runs to the top of the limit
      send_point(32'sh01000000, 32'shFF000000);

      drain();
      if (board.errors == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end
endmodule

// File: sim.f
src/mbet_pkg.sv
src/mbet_if.sv
src/mbet_datapath.sv
src/mbet_ctrl.sv
src/multibrot_escape_time.sv
dv/multibrot_escape_time_scoreboard.sv
dv/multibrot_escape_time_test.sv
